FILE: rtl/cnts_pkg.sv
// ----------------------------------------------------------------------------
// cnts_pkg
// Shared constants, types and fixed-point helpers of the Crank-Nicolson
// tridiagonal step block.
// ----------------------------------------------------------------------------
package cnts_pkg;

  localparam int GRID_POINTS = 64;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 48;
  localparam int ACC_W       = 50;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_STEPS   = 48;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUB   = 3'd0,
    REG_DIAG  = 3'd1,
    REG_SUPER = 3'd2,
    REG_RHS   = 3'd3,
    REG_LEFT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_FILL,
    ST_RD_M1,
    ST_RD_0,
    ST_MUL_C,
    ST_MUL_S,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_LC,
    ST_DEN,
    ST_NUM,
    ST_DIVC_GO,
    ST_DIVC_WAIT,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_BK_RD,
    ST_BK_MUL,
    ST_BK_WR,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_RC_Y0,
    MUL_SUB_YM1,
    MUL_SUP_YP1,
    MUL_A_CP,
    MUL_A_DP,
    MUL_BK
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB
  } acc_op_t;

  // controller to datapath
  typedef struct packed {
    logic             old_we;
    logic             cp_we;
    logic             dp_we;
    logic             dp_bk;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic             ld_ym1;
    logic             ld_yp1;
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic             first;
    logic             last_row;
    logic             ld_d;
    logic             ld_den;
    logic             ld_num;
    logic             div_start;
    logic             div_num_sel;
    logic             ld_cp_new;
    logic             fwd_wr;
    logic             ld_dq;
    logic             out_load;
    logic             out_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_xfer;
  } sts_t;

  // Q16.16 product, floored
  function automatic logic signed [PROD_W-1:0] qmul(input logic signed [DATA_W-1:0] x,
                                                     input logic signed [DATA_W-1:0] y);
    logic signed [2*DATA_W-1:0] p;
    p = x * y;
    return p[2*DATA_W-1:16];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
    return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_word(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

FILE: rtl/cnts_if.sv
// ----------------------------------------------------------------------------
// cnts_if
// Valid/ready channels of the Crank-Nicolson tridiagonal step block.
// ----------------------------------------------------------------------------
interface cnts_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] old_sample;
  logic               is_final;
  modport source (output valid, output old_sample, output is_final, input ready);
  modport sink   (input valid, input old_sample, input is_final, output ready);
endinterface

interface cnts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_sample;
  logic               end_of_grid;
  modport source (output valid, output new_sample, output end_of_grid, input ready);
  modport sink   (input valid, input new_sample, input end_of_grid, output ready);
endinterface

FILE: rtl/cnts_ram.sv
// ----------------------------------------------------------------------------
// cnts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cnts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cnts_divider.sv
// ----------------------------------------------------------------------------
// cnts_divider
// Q16.16 signed divider: (num * 2^16) / den, truncated toward zero and
// saturated; one quotient bit per cycle, restoring form on magnitudes.
// ----------------------------------------------------------------------------
module cnts_divider
  import cnts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     done,
  output logic signed [DATA_W-1:0] quot
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  step;
  logic [DATA_W-1:0]     rem;
  logic [PROD_W-1:0]     qsh;
  logic [DATA_W-1:0]     dvs;
  logic                  neg;
  logic                  den_zero;
  logic                  num_pos;
  logic                  num_neg;

  logic [DATA_W:0]       rem_sh;
  logic [DATA_W:0]       rem_diff;
  logic                  take;
  logic [DATA_W-1:0]     num_mag;
  logic [DATA_W-1:0]     den_mag;

  // magnitudes of the operands
  always_comb begin
    num_mag  = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    den_mag  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    rem_sh   = {rem, qsh[PROD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    take     = !rem_diff[DATA_W];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      qsh      <= {num_mag, 16'h0000};
      dvs      <= den_mag;
      neg      <= num[DATA_W-1] ^ den[DATA_W-1];
      den_zero <= (den == '0);
      num_pos  <= !num[DATA_W-1] && (num != '0);
      num_neg  <= num[DATA_W-1];
    end else if (busy) begin
      rem <= take ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      qsh <= {qsh[PROD_W-2:0], take};
    end
  end

  // sign and saturation of the finished quotient
  always_comb begin
    priority if (den_zero) begin
      quot = num_pos ? Q_MAX : (num_neg ? Q_MIN : '0);
    end else if (!neg && (qsh[PROD_W-1:DATA_W-1] != '0)) begin
      quot = Q_MAX;
    end else if (neg && (qsh > PROD_W'(48'h0000_8000_0000))) begin
      quot = Q_MIN;
    end else if (neg) begin
      quot = DATA_W'(-qsh[DATA_W-1:0]);
    end else begin
      quot = qsh[DATA_W-1:0];
    end
  end

endmodule

FILE: rtl/cnts_datapath.sv
// ----------------------------------------------------------------------------
// cnts_datapath
// Configuration registers, sample and coefficient memories, shared multiplier,
// accumulator, divider and output register.
// ----------------------------------------------------------------------------
module cnts_datapath
  import cnts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic signed [DATA_W-1:0] old_sample,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] new_sample,
  output logic                     end_of_grid
);

  logic signed [DATA_W-1:0] sub_coeff, diag_coeff, super_coeff, rhs_center, left_boundary;

  logic [DATA_W-1:0]        old_q, cp_q, dp_q;
  logic signed [DATA_W-1:0] ym1, yp1, d_reg, den_reg, num_reg, cp_new, cp_prev, dp_prev, dq;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] a_c, b_c, c_c, d_c, mx, my, bk_val, dp_wdata;
  logic signed [DATA_W-1:0] div_num, div_quot;
  logic                     div_done;
  logic                     edge_row;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_coeff     <= '0;
      diag_coeff    <= ONE_Q16;
      super_coeff   <= '0;
      rhs_center    <= ONE_Q16;
      left_boundary <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SUB:   sub_coeff     <= cfg_data;
        REG_DIAG:  diag_coeff    <= cfg_data;
        REG_SUPER: super_coeff   <= cfg_data;
        REG_RHS:   rhs_center    <= cfg_data;
        REG_LEFT:  left_boundary <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  cnts_ram #(.WIDTH(DATA_W), .DEPTH(GRID_POINTS)) u_old_ram (
    .clk(clk), .we(cmd.old_we), .waddr(cmd.waddr), .wdata(old_sample),
    .raddr(cmd.raddr), .rdata(old_q)
  );

  cnts_ram #(.WIDTH(DATA_W), .DEPTH(GRID_POINTS)) u_cp_ram (
    .clk(clk), .we(cmd.cp_we), .waddr(cmd.waddr), .wdata(cp_new),
    .raddr(cmd.raddr), .rdata(cp_q)
  );

  cnts_ram #(.WIDTH(DATA_W), .DEPTH(GRID_POINTS)) u_dp_ram (
    .clk(clk), .we(cmd.dp_we), .waddr(cmd.waddr), .wdata(dp_wdata),
    .raddr(cmd.raddr), .rdata(dp_q)
  );

  // row coefficients; edge rows are pinned
  always_comb begin
    edge_row = cmd.first || cmd.last_row;
    a_c      = edge_row ? '0 : sub_coeff;
    b_c      = edge_row ? ONE_Q16 : diag_coeff;
    c_c      = edge_row ? '0 : super_coeff;
    priority if (cmd.first) begin
      d_c = left_boundary;
    end else if (cmd.last_row) begin
      d_c = ym1;
    end else begin
      d_c = sat32(acc);
    end
    bk_val   = sat32(ext_word(dq) - ext_prod(prod));
    dp_wdata = cmd.dp_bk ? bk_val : div_quot;
    div_num  = cmd.div_num_sel ? num_reg : c_c;
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RC_Y0:   begin mx = rhs_center;  my = old_q;   end
      MUL_SUB_YM1: begin mx = sub_coeff;   my = ym1;     end
      MUL_SUP_YP1: begin mx = super_coeff; my = yp1;     end
      MUL_A_CP:    begin mx = a_c; my = cmd.first ? '0 : cp_prev; end
      MUL_A_DP:    begin mx = a_c; my = cmd.first ? '0 : dp_prev; end
      MUL_BK:      begin mx = cp_q;        my = dp_prev; end
      default:     begin mx = '0;          my = '0;      end
    endcase
  end

  // product, accumulator and row registers
  always_ff @(posedge clk) begin
    prod <= qmul(mx, my);
    unique case (cmd.acc_op)
      ACC_LOAD: acc <= ext_prod(prod);
      ACC_SUB:  acc <= acc - ext_prod(prod);
      ACC_HOLD: acc <= acc;
      default:  acc <= acc;
    endcase
    if (cmd.ld_ym1)    ym1     <= old_q;
    if (cmd.ld_yp1)    yp1     <= old_q;
    if (cmd.ld_d)      d_reg   <= d_c;
    if (cmd.ld_den)    den_reg <= sat32(ext_word(b_c) - ext_prod(prod));
    if (cmd.ld_num)    num_reg <= sat32(ext_word(d_reg) - ext_prod(prod));
    if (cmd.ld_cp_new) cp_new  <= div_quot;
    if (cmd.ld_dq)     dq      <= dp_q;
    if (cmd.fwd_wr) begin
      cp_prev <= cp_new;
      dp_prev <= div_quot;
    end else if (cmd.dp_we && cmd.dp_bk) begin
      dp_prev <= bk_val;
    end
  end

  cnts_divider u_divider (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(den_reg),
    .done(div_done), .quot(div_quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      new_sample  <= dp_q;
      end_of_grid <= cmd.out_end;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_xfer = out_valid && out_ready;

endmodule

FILE: rtl/cnts_ctrl.sv
// ----------------------------------------------------------------------------
// cnts_ctrl
// Sequencer: sample fill, forward elimination, back substitution and
// in-order read-out.
// ----------------------------------------------------------------------------
module cnts_ctrl
  import cnts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic is_final,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] row;
  logic             in_xfer;
  logic             fill_end;
  logic             last_row;

  assign in_xfer  = in_valid && (state == ST_FILL);
  assign fill_end = is_final || (cnt == CNT_W'(GRID_POINTS - 1));
  assign last_row = (row == rows - 1'b1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL:      if (in_xfer && fill_end) state_next = ST_RD_M1;
      ST_RD_M1:     state_next = ST_RD_0;
      ST_RD_0:      state_next = ST_MUL_C;
      ST_MUL_C:     state_next = ST_MUL_S;
      ST_MUL_S:     state_next = ST_MUL_P;
      ST_MUL_P:     state_next = ST_ACC_P;
      ST_ACC_P:     state_next = ST_MUL_LC;
      ST_MUL_LC:    state_next = ST_DEN;
      ST_DEN:       state_next = ST_NUM;
      ST_NUM:       state_next = ST_DIVC_GO;
      ST_DIVC_GO:   state_next = ST_DIVC_WAIT;
      ST_DIVC_WAIT: if (sts.div_done) state_next = ST_DIVD_GO;
      ST_DIVD_GO:   state_next = ST_DIVD_WAIT;
      ST_DIVD_WAIT: begin
        if (sts.div_done) begin
          priority if (!last_row) state_next = ST_RD_M1;
          else if (rows == CNT_W'(1)) state_next = ST_OUT_RD;
          else state_next = ST_BK_RD;
        end
      end
      ST_BK_RD:     state_next = ST_BK_MUL;
      ST_BK_MUL:    state_next = ST_BK_WR;
      ST_BK_WR:     state_next = (row == '0) ? ST_OUT_RD : ST_BK_RD;
      ST_OUT_RD:    state_next = ST_OUT_LD;
      ST_OUT_LD:    state_next = ST_OUT_WAIT;
      ST_OUT_WAIT:  if (sts.out_xfer) state_next = last_row ? ST_FILL : ST_OUT_RD;
      default:      state_next = ST_FILL;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_RC_Y0;
    cmd.acc_op   = ACC_HOLD;
    cmd.first    = (row == '0);
    cmd.last_row = last_row;
    cmd.waddr    = row[IDX_W-1:0];
    cmd.raddr    = row[IDX_W-1:0];
    in_ready     = 1'b0;
    unique case (state)
      ST_FILL: begin
        in_ready   = 1'b1;
        cmd.old_we = in_valid;
        cmd.waddr  = cnt[IDX_W-1:0];
      end
      ST_RD_M1:  cmd.raddr = IDX_W'(row - 1'b1);
      ST_RD_0:   cmd.ld_ym1 = 1'b1;
      ST_MUL_C: begin
        cmd.mul_sel = MUL_RC_Y0;
        cmd.raddr   = IDX_W'(row + 1'b1);
      end
      ST_MUL_S: begin
        cmd.ld_yp1  = 1'b1;
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_SUB_YM1;
      end
      ST_MUL_P: begin
        cmd.acc_op  = ACC_SUB;
        cmd.mul_sel = MUL_SUP_YP1;
      end
      ST_ACC_P:  cmd.acc_op = ACC_SUB;
      ST_MUL_LC: begin
        cmd.ld_d    = 1'b1;
        cmd.mul_sel = MUL_A_CP;
      end
      ST_DEN: begin
        cmd.ld_den  = 1'b1;
        cmd.mul_sel = MUL_A_DP;
      end
      ST_NUM:       cmd.ld_num = 1'b1;
      ST_DIVC_GO:   cmd.div_start = 1'b1;
      ST_DIVC_WAIT: cmd.ld_cp_new = sts.div_done;
      ST_DIVD_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_num_sel = 1'b1;
      end
      ST_DIVD_WAIT: begin
        cmd.fwd_wr = sts.div_done;
        cmd.cp_we  = sts.div_done;
        cmd.dp_we  = sts.div_done;
      end
      ST_BK_RD:  ;
      ST_BK_MUL: begin
        cmd.mul_sel = MUL_BK;
        cmd.ld_dq   = 1'b1;
      end
      ST_BK_WR: begin
        cmd.dp_we = 1'b1;
        cmd.dp_bk = 1'b1;
      end
      ST_OUT_RD: ;
      ST_OUT_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_end  = last_row;
      end
      ST_OUT_WAIT: ;
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      cnt   <= '0;
      rows  <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_FILL: begin
          if (in_xfer) begin
            if (fill_end) begin
              rows <= cnt + 1'b1;
              cnt  <= '0;
              row  <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_DIVD_WAIT: begin
          if (sts.div_done) begin
            priority if (!last_row) row <= row + 1'b1;
            else if (rows == CNT_W'(1)) row <= '0;
            else row <= rows - CNT_W'(2);
          end
        end
        ST_BK_WR:    if (row != '0) row <= row - 1'b1;
        ST_OUT_WAIT: if (sts.out_xfer) row <= last_row ? '0 : row + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/crank_nicolson_tridiagonal_step_top.sv
// ----------------------------------------------------------------------------
// crank_nicolson_tridiagonal_step_top
// One Crank-Nicolson time-step of a 1-D advection-diffusion grid, solved by
// the Thomas algorithm in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the previous step's samples in ascending index order; the
//   sample with is_final set (or the 64th) closes the grid. Each sample is one
//   transfer, and in_ch.ready is held high while the block is filling.
//   out_ch then returns the new samples in ascending order, end_of_grid on the
//   last one. No input is taken from the closing sample until the last result
//   has been transferred.
//   Each row of forward elimination uses the shared divider twice; back
//   substitution and read-out follow, the read-out passing through the
//   single read port of the coefficient memory. A stalled receiver holds the
//   result in the output register and the block waits. Configuration writes
//   (cfg_we, cfg_index, cfg_data) are to be made by the user only while idle;
//   the block itself does not enforce this. Synchronous reset returns the
//   block to filling with an empty grid and the coefficients at their defaults.
// ----------------------------------------------------------------------------
module crank_nicolson_tridiagonal_step_top
  import cnts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  cnts_in_if.sink              in_ch,
  cnts_out_if.source           out_ch
);

  cmd_t cmd;
  sts_t sts;

  cnts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .is_final(in_ch.is_final),
    .in_ready(in_ch.ready), .sts(sts), .cmd(cmd)
  );

  cnts_datapath u_datapath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .old_sample(in_ch.old_sample), .cmd(cmd), .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .new_sample(out_ch.new_sample), .end_of_grid(out_ch.end_of_grid)
  );

endmodule

FILE: rtl/cnts_checker.sv
// ----------------------------------------------------------------------------
// cnts_checker
// Port-level checks of the Crank-Nicolson tridiagonal step block.
// ----------------------------------------------------------------------------
module cnts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_sample,
  input logic        end_of_grid
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(new_sample) && $stable(end_of_grid))
    else $error("stalled result changed");

  // filling and read-out never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is offered");

  // each result is fetched afresh after its transfer
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result offered straight after a transfer");

endmodule

bind crank_nicolson_tridiagonal_step_top cnts_checker u_cnts_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .new_sample(out_ch.new_sample), .end_of_grid(out_ch.end_of_grid)
);
